// ===== design/point_cloud_top_side_histogram_core_assert.svh =====
`ifndef POINT_CLOUD_TOP_SIDE_HISTOGRAM_CORE_ASSERT_SVH
`define POINT_CLOUD_TOP_SIDE_HISTOGRAM_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCTH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcth assertion failed");

// next-cycle implication
`define PCTH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcth assertion failed");

`endif

// ===== design/pcth_pkg.sv =====
package pcth_pkg;

	localparam int COUNT_W = 16;
	localparam logic [14:0] MAX_DEPTH_RST = 15'd4000;

	localparam logic CMD_ACC = 1'b0;
	localparam logic CMD_RD  = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic [7:0]         bin_row;
		logic [8:0]         bin_col;
	} pt_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] top_count;
		logic [COUNT_W-1:0] side_count;
		logic               top_hit;
		logic               side_hit;
	} res_item_t;

endpackage

// ===== design/point_cloud_top_side_histogram_core.sv =====
// A read-and-clear transaction passes through S_PREP, S_RD, S_WR and S_PUSH,
// a point transaction through S_PREP, S_DIV (restoring divide, one bit per cycle), S_RD,
// S_WR and S_PUSH. One transaction at a time: pt_stall holds off the next until S_IDLE;
// each bin update is a read-modify-write of both count memories.
// Reset: max_depth returns to 4000 and a clearing pass writes zero to all
// ROWS*COLS entries, one per cycle, while pt_stall stays high.
module point_cloud_top_side_histogram_core
	import pcth_pkg::*;
#(
	parameter int ROWS = 256,
	parameter int COLS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pt_valid,
	output logic        pt_stall,
	input  pt_item_t    pt,
	output logic        res_valid,
	input  logic        res_stall,
	output res_item_t   res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	localparam int QW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);
	localparam int NB    = ROWS * COLS;
	localparam int AW    = $clog2(NB);
	localparam int NW    = 16 + QW;
	localparam int SHIFT = (COLS - ROWS) / 2;
	localparam int CSW   = ((QW > CW) ? QW : CW) + 2;

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_PREP, S_DIV, S_RD, S_WR, S_PUSH} state_t;

	state_t          state_q;
	pt_item_t        item_q;
	logic [14:0]     max_depth_q;
	logic [AW-1:0]   clr_q;
	logic            top_ok_q, side_ok_q;
	logic            top_we_q, side_we_q;
	logic [AW-1:0]   top_addr_q, side_addr_q;
	res_item_t       res_q;
	res_item_t       out_q;
	logic            out_valid_q;

	logic signed [17:0] m, x2, y2, z, dz;
	logic               zc, tc, sc;
	logic [15:0]        n_tr, n_tc, n_sr, n_sc, den;
	logic [NW-1:0]      num_tr, num_tc, num_sr, num_sc;
	logic               div_start;
	logic               busy_tr, busy_tc, busy_sr, busy_sc;
	logic [QW-1:0]      q_tr, q_tc, q_sr, q_sc;
	logic signed [CSW-1:0] tcol, scol;
	logic               tcol_ok, scol_ok;
	logic [AW-1:0]      acc_taddr, acc_saddr, rd_addr;
	logic               rd_ok;
	logic               top_we, side_we;
	logic [AW-1:0]      top_waddr, side_waddr;
	logic [15:0]        top_wdata, side_wdata, top_rdata, side_rdata;
	logic [15:0]        top_inc, side_inc;

	always_comb begin
		m    = $signed({3'b000, max_depth_q});
		x2   = $signed({item_q.point_x[15], item_q.point_x, 1'b0});
		y2   = $signed({item_q.point_y[15], item_q.point_y, 1'b0});
		z    = $signed({{2{item_q.point_z[15]}}, item_q.point_z});
		dz   = m - z;
		zc   = (z > 18'sd0) && (z < m);
		tc   = zc && (x2 > -m) && (x2 < m);
		sc   = zc && (y2 > -m) && (y2 < m);
		n_tr = {dz[14:0], 1'b0};
		n_tc = 16'(m + x2);
		n_sr = 16'(m + y2);
		n_sc = {z[14:0], 1'b0};
		den  = {max_depth_q, 1'b0};
		num_tr = NW'(ROWS) * NW'(n_tr);
		num_tc = NW'(ROWS) * NW'(n_tc);
		num_sr = NW'(ROWS) * NW'(n_sr);
		num_sc = NW'(ROWS) * NW'(n_sc);
	end

	assign div_start = (state_q == S_PREP) && (item_q.cmd == CMD_ACC);

	pcth_div #(.QW(QW), .NW(NW)) u_div_tr (
		.clk, .arst_n, .start(div_start), .num(num_tr), .den, .busy(busy_tr), .quo(q_tr)
	);
	pcth_div #(.QW(QW), .NW(NW)) u_div_tc (
		.clk, .arst_n, .start(div_start), .num(num_tc), .den, .busy(busy_tc), .quo(q_tc)
	);
	pcth_div #(.QW(QW), .NW(NW)) u_div_sr (
		.clk, .arst_n, .start(div_start), .num(num_sr), .den, .busy(busy_sr), .quo(q_sr)
	);
	pcth_div #(.QW(QW), .NW(NW)) u_div_sc (
		.clk, .arst_n, .start(div_start), .num(num_sc), .den, .busy(busy_sc), .quo(q_sc)
	);

	always_comb begin
		tcol    = $signed(CSW'(q_tc)) + $signed(CSW'(SHIFT));
		scol    = $signed(CSW'(q_sc)) + $signed(CSW'(SHIFT));
		tcol_ok = !tcol[CSW-1] && (tcol < $signed(CSW'(COLS)));
		scol_ok = !scol[CSW-1] && (scol < $signed(CSW'(COLS)));
		acc_taddr = AW'(32'(q_tr) * COLS + 32'(unsigned'(tcol)));
		acc_saddr = AW'(32'(q_sr) * COLS + 32'(unsigned'(scol)));
		rd_ok   = (32'(item_q.bin_row) < ROWS) && (32'(item_q.bin_col) < COLS);
		rd_addr = AW'(32'(item_q.bin_row) * COLS + 32'(item_q.bin_col));
	end

	assign top_inc  = (top_rdata == 16'hFFFF) ? top_rdata : top_rdata + 16'd1;
	assign side_inc = (side_rdata == 16'hFFFF) ? side_rdata : side_rdata + 16'd1;

	always_comb begin
		if (state_q == S_CLR) begin
			top_we     = 1'b1;
			side_we    = 1'b1;
			top_waddr  = clr_q;
			side_waddr = clr_q;
			top_wdata  = '0;
			side_wdata = '0;
		end else begin
			top_we     = (state_q == S_WR) && top_we_q;
			side_we    = (state_q == S_WR) && side_we_q;
			top_waddr  = top_addr_q;
			side_waddr = side_addr_q;
			top_wdata  = (item_q.cmd == CMD_RD) ? 16'd0 : top_inc;
			side_wdata = (item_q.cmd == CMD_RD) ? 16'd0 : side_inc;
		end
	end

	pcth_ram #(.WIDTH(COUNT_W), .DEPTH(NB)) u_top_ram (
		.clk, .we(top_we), .waddr(top_waddr), .wdata(top_wdata),
		.raddr(top_addr_q), .rdata(top_rdata)
	);
	pcth_ram #(.WIDTH(COUNT_W), .DEPTH(NB)) u_side_ram (
		.clk, .we(side_we), .waddr(side_waddr), .wdata(side_wdata),
		.raddr(side_addr_q), .rdata(side_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			max_depth_q <= MAX_DEPTH_RST;
			out_valid_q <= 1'b0;
			top_we_q    <= 1'b0;
			side_we_q   <= 1'b0;
			top_ok_q    <= 1'b0;
			side_ok_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_depth_q <= cfg_data;
			end
			if (out_valid_q && !res_stall && (state_q != S_PUSH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NB - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pt_valid) begin
						item_q  <= pt;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					top_ok_q  <= tc;
					side_ok_q <= sc;
					if (item_q.cmd == CMD_RD) begin
						top_addr_q  <= rd_addr;
						side_addr_q <= rd_addr;
						top_we_q    <= rd_ok;
						side_we_q   <= rd_ok;
						state_q     <= S_RD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!(busy_tr || busy_tc || busy_sr || busy_sc)) begin
						top_addr_q  <= acc_taddr;
						side_addr_q <= acc_saddr;
						top_we_q    <= top_ok_q && tcol_ok;
						side_we_q   <= side_ok_q && scol_ok;
						state_q     <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (item_q.cmd == CMD_RD) begin
						res_q.top_count  <= top_we_q ? top_rdata : 16'd0;
						res_q.side_count <= side_we_q ? side_rdata : 16'd0;
						res_q.top_hit    <= 1'b0;
						res_q.side_hit   <= 1'b0;
					end else begin
						res_q.top_count  <= 16'd0;
						res_q.side_count <= 16'd0;
						res_q.top_hit    <= top_we_q;
						res_q.side_hit   <= side_we_q;
					end
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!out_valid_q || !res_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pt_stall  = (state_q != S_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign cfg_ready = 1'b1;

endmodule

// ===== design/pcth_ram.sv =====
module pcth_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/pcth_div.sv =====
module pcth_div #(
	parameter int QW = 8,
	parameter int NW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [15:0]   den,
	output logic          busy,
	output logic [QW-1:0] quo
);

	localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

	logic [NW-1:0]   rem_q;
	logic [NW-1:0]   dsh_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(QW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NW'(den) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= (quo_q << 1) | QW'(ge);
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== design/pcth_checker.sv =====
`include "point_cloud_top_side_histogram_core_assert.svh"

module pcth_checker
	import pcth_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      pt_valid,
	input logic      pt_stall,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res,
	input logic      cfg_valid,
	input logic      cfg_ready
);

	`PCTH_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	`PCTH_ASSERT_NOW(a_hit_zero, res_valid && (res.top_hit || res.side_hit), (res.top_count == 16'd0) && (res.side_count == 16'd0))
	`PCTH_ASSERT_NEXT(a_one_at_a_time, pt_valid && !pt_stall, pt_stall)
	`PCTH_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind point_cloud_top_side_histogram_core pcth_checker u_pcth_checker (.*);
